FILE: rtl/pmq_pkg.sv
// Shared types, constants and pointer helpers for the priority message queue.
`default_nettype none

package pmq_pkg;

  localparam int QUEUE_DEPTH   = 32;
  localparam int PAYLOAD_BYTES = 8;
  localparam int PTR_W         = $clog2(QUEUE_DEPTH);
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam int PAYLOAD_W = 64;
  localparam int LEN_W     = 4;
  localparam int PRIO_W    = 8;
  localparam int OCC_W     = 6;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 88;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 4'd8;

  localparam logic OP_SEND = 1'b0;
  localparam logic OP_RECV = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [PRIO_W-1:0]    priority_v;
    logic [LEN_W-1:0]     length_v;
    logic [PAYLOAD_W-1:0] payload_v;
  } entry_t;

  function automatic ptr_t ptr_inc(ptr_t p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic ptr_t ptr_dec(ptr_t p);
    return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

  // a + n modulo the queue depth; a < depth, n <= depth
  function automatic ptr_t ptr_add(ptr_t a, cnt_t n);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(a) + (CNT_W+1)'(n);
    if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      s = s - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  // keep the low min(len, PAYLOAD_BYTES) bytes
  function automatic logic [PAYLOAD_W-1:0] keep_bytes(logic [PAYLOAD_W-1:0] v,
                                                      logic [LEN_W-1:0] len);
    logic [PAYLOAD_W-1:0] r;
    r = '0;
    for (int b = 0; b < PAYLOAD_W / 8; b++) begin
      if (b < PAYLOAD_BYTES && LEN_W'(b) < len) begin
        r[8*b +: 8] = v[8*b +: 8];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/priority_message_queue_unit.sv
// Priority message queue: sorted circular store in one RAM, sequenced by an FSM.
//
//  channel  | dir | signals                         | contents
//  ---------+-----+---------------------------------+------------------------------
//  in_      | in  | tvalid tready tdata tuser       | send/receive request
//  out_     | out | tvalid tready tdata tuser       | status and received message
//  cfg_     | in  | wr_en wr_data                   | max_length register
//
// Receive: accept, RAM read, load. Send: accept, then a walk from the tail that moves
// one entry per cycle through the RAM over at most count entries (count = messages
// held, at most 31 for an accepted send), then load. A rejected request goes from
// accept to load. Reset clears the count and head pointer and sets the length limit
// to MAX_LEN_RESET; the RAM keeps its contents. A new request is taken while a result
// still waits in the output register; the FSM stalls only when a second result is due.
`default_nettype none

module priority_message_queue_unit
  import pmq_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  wire [IN_DATA_W-1:0]   in_tdata,   // payload[63:0] length[67:64] priority_req[75:68]
  input  wire                   in_tuser,   // op
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // out_payload[63:0] out_length[67:64]
                                            // out_priority[75:68] occupancy[81:76]
  output logic [1:0]            out_tuser,  // status
  input  wire                   cfg_wr_en,
  input  wire [LEN_W-1:0]       cfg_wr_data
);

  typedef enum logic [2:0] {S_IDLE, S_RECV, S_SCAN, S_INS, S_FIN} state_t;

  state_t         state_r, state_nxt;
  ptr_t           head_r, head_nxt;
  cnt_t           count_r, count_nxt;
  ptr_t           rd_ptr_r, rd_ptr_nxt;
  ptr_t           k_r, k_nxt;
  logic [LEN_W-1:0] max_len_r;
  entry_t         new_r, new_nxt;
  status_t        res_status_r, res_status_nxt;
  entry_t         res_entry_r, res_entry_nxt;
  logic           out_valid_r, out_valid_nxt;
  status_t        out_status_r, out_status_nxt;
  entry_t         out_entry_r, out_entry_nxt;
  logic [OCC_W-1:0] out_occ_r, out_occ_nxt;

  entry_t         mem [QUEUE_DEPTH];
  entry_t         rd_data_r;
  logic           mem_we;
  ptr_t           mem_waddr, mem_raddr;
  entry_t         mem_wdata;

  entry_t         in_entry;
  ptr_t           tail_ptr;

  assign in_entry = {in_tdata[75:68], in_tdata[67:64],
                     keep_bytes(in_tdata[63:0], in_tdata[67:64])};
  assign tail_ptr = ptr_add(head_r, count_r - 1'b1);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    rd_ptr_nxt     = rd_ptr_r;
    k_nxt          = k_r;
    new_nxt        = new_r;
    res_status_nxt = res_status_r;
    res_entry_nxt  = res_entry_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    out_occ_nxt    = out_occ_r;
    mem_we         = 1'b0;
    mem_waddr      = head_r;
    mem_wdata      = new_r;
    mem_raddr      = head_r;
    in_tready      = (state_r == S_IDLE);

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          new_nxt        = in_entry;
          res_entry_nxt  = '0;
          res_status_nxt = ST_OK;
          state_nxt      = S_FIN;
          if (in_tuser == OP_RECV) begin
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              mem_raddr = head_r;
              state_nxt = S_RECV;
            end
          end else if (in_entry.length_v > max_len_r) begin
            res_status_nxt = ST_TOO_LONG;
          end else if (count_r == CNT_W'(QUEUE_DEPTH)) begin
            res_status_nxt = ST_FULL;
          end else if (count_r == '0) begin
            mem_we    = 1'b1;
            mem_waddr = head_r;
            mem_wdata = in_entry;
            count_nxt = count_r + 1'b1;
          end else begin
            // walk from the tail toward the head
            mem_raddr  = tail_ptr;
            rd_ptr_nxt = tail_ptr;
            k_nxt      = PTR_W'(count_r - 1'b1);
            state_nxt  = S_SCAN;
          end
        end
      end
      S_RECV: begin
        res_entry_nxt = rd_data_r;
        head_nxt      = ptr_inc(head_r);
        count_nxt     = count_r - 1'b1;
        state_nxt     = S_FIN;
      end
      S_SCAN: begin
        // rd_data_r holds the entry at rd_ptr_r; the next one down is fetched
        mem_we     = 1'b1;
        mem_waddr  = ptr_inc(rd_ptr_r);
        mem_raddr  = ptr_dec(rd_ptr_r);
        rd_ptr_nxt = ptr_dec(rd_ptr_r);
        if (rd_data_r.priority_v >= new_r.priority_v) begin
          mem_wdata = new_r;
          count_nxt = count_r + 1'b1;
          state_nxt = S_FIN;
        end else begin
          mem_wdata = rd_data_r;
          if (k_r == '0) begin
            state_nxt = S_INS;
          end else begin
            k_nxt = k_r - 1'b1;
          end
        end
      end
      S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = head_r;
        mem_wdata = new_r;
        count_nxt = count_r + 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_entry_nxt  = res_entry_r;
          out_occ_nxt    = OCC_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      max_len_r   <= MAX_LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
    end
    rd_ptr_r     <= rd_ptr_nxt;
    k_r          <= k_nxt;
    new_r        <= new_nxt;
    res_status_r <= res_status_nxt;
    res_entry_r  <= res_entry_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(OUT_DATA_W - OCC_W - $bits(entry_t)){1'b0}}, out_occ_r, out_entry_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("held count above queue depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r == $past(count_r) || count_r == $past(count_r) + 1'b1 ||
              count_r + 1'b1 == $past(count_r)))
    else $error("held count moved by more than one");

  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && (!out_valid_r || out_tready) |=> out_valid_r && state_r == S_IDLE)
    else $error("finished result not loaded into output register");

  a_scan_ports: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN && k_r != '0 |-> mem_waddr != mem_raddr)
    else $error("walk reads and writes the same entry");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_entry_r == '0)
    else $error("failed request returns message data");

endmodule

`default_nettype wire

FILE: tb/priority_message_queue_unit_test.sv
// Self-checking testbench for the priority message queue unit: directed cases, then random traffic.
`timescale 1ns / 1ps

module priority_message_queue_unit_test;
  import pmq_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int REPORT_LIMIT   = 100;

  typedef struct {
    logic [PAYLOAD_W-1:0] payload;
    logic [LEN_W-1:0]     length;
    logic [PRIO_W-1:0]    prio;
  } message_t;

  typedef struct {
    status_t              status;
    logic [PAYLOAD_W-1:0] payload;
    logic [LEN_W-1:0]     length;
    logic [PRIO_W-1:0]    prio;
    logic [OCC_W-1:0]     occupancy;
  } queue_result_t;

  typedef enum {TRAFFIC_FILL, TRAFFIC_DRAIN, TRAFFIC_EVEN} traffic_mode_t;
  typedef enum {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_BLOCKS} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_wr_en = 1'b0;
  logic [LEN_W-1:0]      cfg_wr_data = '0;

  // shadow of the queue contents, head at index 0
  message_t        held_msgs[$];
  queue_result_t   pending_results[$];
  logic [LEN_W-1:0] max_len_model = MAX_LEN_RESET;
  int              error_count = 0;
  int              burst_left = 0;
  int              idle_cycles = 0;

  priority_message_queue_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [PAYLOAD_W-1:0] trim_payload(logic [PAYLOAD_W-1:0] v,
                                                        logic [LEN_W-1:0] len);
    if (len >= PAYLOAD_BYTES) begin
      return v;
    end
    return v & ((64'd1 << (8 * len)) - 64'd1);
  endfunction

  // applies one request to the shadow queue and returns the result it should give
  function automatic queue_result_t apply_queue_op(logic op, logic [PAYLOAD_W-1:0] payload,
                                                   logic [LEN_W-1:0] len,
                                                   logic [PRIO_W-1:0] prio);
    queue_result_t r;
    message_t m;
    int pos;
    r.status  = ST_OK;
    r.payload = '0;
    r.length  = '0;
    r.prio    = '0;
    if (op == OP_SEND) begin
      // length check wins over the full check
      if (len > max_len_model) begin
        r.status = ST_TOO_LONG;
      end else if (held_msgs.size() >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_msgs.size() && held_msgs[pos].prio >= prio) pos++;
        m.payload = trim_payload(payload, len);
        m.length  = len;
        m.prio    = prio;
        held_msgs.insert(pos, m);
      end
    end else if (held_msgs.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      m = held_msgs.pop_front();
      r.payload = m.payload;
      r.length  = m.length;
      r.prio    = m.prio;
    end
    r.occupancy = OCC_W'(held_msgs.size());
    return r;
  endfunction

  // bias toward a few shared values so equal priorities are common
  function automatic logic [PRIO_W-1:0] pick_priority();
    case ($urandom_range(0, 3))
      0: return PRIO_W'($urandom_range(0, 255));
      1: return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
      default: return PRIO_W'($urandom_range(100, 103));
    endcase
  endfunction

  function automatic logic [PAYLOAD_W-1:0] pick_payload();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_length(bit fit);
    if (fit) begin
      return LEN_W'($urandom_range(0, int'(max_len_model)));
    end
    return LEN_W'($urandom_range(0, 15));
  endfunction

  task automatic report_error(string msg);
    if (error_count < REPORT_LIMIT) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  task automatic send_request(input logic op, input logic [PAYLOAD_W-1:0] payload,
                              input logic [LEN_W-1:0] len, input logic [PRIO_W-1:0] prio);
    int gap;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 16);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, prio, len, payload};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    pending_results.push_back(apply_queue_op(op, payload, len, prio));
  endtask

  // receive request; the unused fields carry noise
  task automatic receive_head();
    send_request(OP_RECV, pick_payload(), pick_length(1'b0), PRIO_W'($urandom_range(0, 255)));
  endtask

  task automatic wait_until_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [LEN_W-1:0] v);
    wait_until_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    max_len_model = v;
  endtask

  task automatic test_empty_and_limits();
    receive_head();
    send_request(OP_SEND, '1, 4'd9, 8'd10);
    send_request(OP_SEND, '1, 4'd15, 8'hff);
    send_request(OP_SEND, '1, 4'd8, 8'hff);
    send_request(OP_SEND, '1, 4'd0, 8'h00);
    send_request(OP_SEND, 64'h0123_4567_89ab_cdef, 4'd3, 8'd128);
  endtask

  task automatic test_priority_order();
    send_request(OP_SEND, 64'h1111, 4'd2, 8'd7);
    send_request(OP_SEND, 64'h2222, 4'd2, 8'd200);
    send_request(OP_SEND, 64'h3333, 4'd2, 8'd7);
    send_request(OP_SEND, 64'h4444, 4'd2, 8'd0);
    repeat (8) receive_head();
  endtask

  task automatic test_length_register_extremes();
    write_max_length(4'd0);
    send_request(OP_SEND, '1, 4'd0, 8'd50);
    send_request(OP_SEND, '1, 4'd1, 8'd50);
    receive_head();
    write_max_length(4'd15);
    send_request(OP_SEND, '1, 4'd15, 8'hff);
    send_request(OP_SEND, {$urandom, $urandom}, 4'd9, 8'd1);
    repeat (3) receive_head();
  endtask

  task automatic test_fill_and_drain();
    while (held_msgs.size() < QUEUE_DEPTH) begin
      send_request(OP_SEND, pick_payload(), pick_length(1'b1), pick_priority());
    end
    if (max_len_model < 4'd15) begin
      send_request(OP_SEND, pick_payload(),
                   LEN_W'($urandom_range(int'(max_len_model) + 1, 15)), pick_priority());
    end
    repeat (2) send_request(OP_SEND, pick_payload(), pick_length(1'b1), pick_priority());
    while (held_msgs.size() > 0) receive_head();
    receive_head();
  endtask

  task automatic test_random_traffic(input int count);
    traffic_mode_t mode;
    int mode_left;
    int send_pct;
    mode = TRAFFIC_EVEN;
    mode_left = 0;
    repeat (count) begin
      if (mode_left == 0) begin
        mode = traffic_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      case (mode)
        TRAFFIC_FILL:  send_pct = 85;
        TRAFFIC_DRAIN: send_pct = 15;
        default:       send_pct = 50;
      endcase
      if ($urandom_range(0, 99) < send_pct) begin
        send_request(OP_SEND, pick_payload(), pick_length($urandom_range(0, 4) != 0),
                     pick_priority());
      end else begin
        receive_head();
      end
      if ($urandom_range(0, 199) == 0) begin
        wait_until_drained();
      end
    end
  endtask

  initial begin : rx_pattern
    rx_mode_t rx_mode;
    int span;
    forever begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      for (int k = 0; k < span; k++) begin
        @(negedge clk);
        case (rx_mode)
          RX_ALWAYS: out_tready <= 1'b1;
          RX_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
          RX_RARELY: out_tready <= ($urandom_range(0, 3) == 0);
          default:   out_tready <= ((k % 24) < 12);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    queue_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_error("result with no request outstanding");
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tuser !== exp_r.status)
          report_error($sformatf("status %0d, expected %0d", out_tuser, exp_r.status));
        if (out_tdata[63:0] !== exp_r.payload)
          report_error($sformatf("payload %h, expected %h", out_tdata[63:0], exp_r.payload));
        if (out_tdata[67:64] !== exp_r.length)
          report_error($sformatf("length %0d, expected %0d", out_tdata[67:64], exp_r.length));
        if (out_tdata[75:68] !== exp_r.prio)
          report_error($sformatf("priority %0d, expected %0d", out_tdata[75:68], exp_r.prio));
        if (out_tdata[81:76] !== exp_r.occupancy)
          report_error($sformatf("occupancy %0d, expected %0d", out_tdata[81:76],
                                 exp_r.occupancy));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("priority_message_queue_unit_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_and_limits();
    test_priority_order();
    test_length_register_extremes();

    write_max_length(4'd15);
    test_fill_and_drain();
    test_random_traffic(180);
    write_max_length(4'd0);
    test_fill_and_drain();
    test_random_traffic(180);
    write_max_length(LEN_W'($urandom_range(1, 7)));
    test_fill_and_drain();
    test_random_traffic(180);
    write_max_length(MAX_LEN_RESET);
    test_fill_and_drain();
    test_random_traffic(180);
    write_max_length(LEN_W'($urandom_range(9, 14)));
    test_fill_and_drain();
    test_random_traffic(180);

    wait_until_drained();
    if (error_count == 0) begin
      $display("priority_message_queue_unit_test: PASS");
    end else begin
      $display("priority_message_queue_unit_test: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pmq_pkg.sv
rtl/priority_message_queue_unit.sv
tb/priority_message_queue_unit_test.sv
